// ===== design/tac_pkg.sv =====
// Shared types, constants and operation codes of the timed actuator controller.
package tac_pkg;

  // Widths of the two elapsed-time counters.
  localparam int MOVE_TIME_BITS  = 20;
  localparam int BLINK_TIME_BITS = 16;

  // Widths of the configuration registers and of the configuration port.
  localparam int MOVE_CFG_W  = 20;
  localparam int BLINK_CFG_W = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 20;

  // Compare widths wide enough for both the counter and its limit.
  localparam int MOVE_CMP_W  = (MOVE_TIME_BITS > MOVE_CFG_W) ? MOVE_TIME_BITS : MOVE_CFG_W;
  localparam int BLINK_CMP_W = (BLINK_TIME_BITS > BLINK_CFG_W) ? BLINK_TIME_BITS : BLINK_CFG_W;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PUMP  = 2'd1;
  localparam logic [1:0] OP_SHADE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_TIME   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PER   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_ACT_HI = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SHADE_ACT_HI = CFG_IDX_W'(3);

  // Reset values of the configuration registers.
  localparam logic [MOVE_CFG_W-1:0]  MOVE_TIME_RST = MOVE_CFG_W'(10000);
  localparam logic [BLINK_CFG_W-1:0] BLINK_PER_RST = BLINK_CFG_W'(500);

  typedef struct packed {
    logic [1:0] op;
    logic       value;
  } in_t;

  typedef struct packed {
    logic pump_pin;
    logic open_pin;
    logic close_pin;
    logic led_pin;
    logic pump_running;
    logic shade_is_open;
    logic shade_in_motion;
  } out_t;

  typedef struct packed {
    logic [MOVE_CFG_W-1:0]  move_time_ms;
    logic [BLINK_CFG_W-1:0] blink_period_ms;
    logic                   pump_active_high;
    logic                   shade_active_high;
  } cfg_t;

endpackage

// ===== design/tac_cfg_regs.sv =====
// Configuration register file of the timed actuator controller.
module tac_cfg_regs import tac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_MOVE_TIME:    cfg_nxt.move_time_ms      = wr_data[MOVE_CFG_W-1:0];
        REG_BLINK_PER:    cfg_nxt.blink_period_ms   = wr_data[BLINK_CFG_W-1:0];
        REG_PUMP_ACT_HI:  cfg_nxt.pump_active_high  = wr_data[0];
        REG_SHADE_ACT_HI: cfg_nxt.shade_active_high = wr_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.move_time_ms      <= MOVE_TIME_RST;
      cfg_r.blink_period_ms   <= BLINK_PER_RST;
      cfg_r.pump_active_high  <= 1'b1;
      cfg_r.shade_active_high <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/tac_core.sv =====
// Actuator state and the single-pass update logic for one transaction.
module tac_core import tac_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic go,
  input  in_t  item,
  input  cfg_t cfg,
  output out_t res
);

  localparam logic [MOVE_TIME_BITS-1:0]  MOVE_MAX  = '1;
  localparam logic [BLINK_TIME_BITS-1:0] BLINK_MAX = '1;

  logic                       pump_r, pump_nxt;
  logic                       pos_r, pos_nxt;
  logic                       mov_r, mov_nxt;
  logic                       tgt_r, tgt_nxt;
  logic                       led_r, led_nxt;
  logic [MOVE_TIME_BITS-1:0]  me_r, me_nxt;
  logic [BLINK_TIME_BITS-1:0] be_r, be_nxt;

  always_comb begin
    pump_nxt = pump_r;
    pos_nxt  = pos_r;
    mov_nxt  = mov_r;
    tgt_nxt  = tgt_r;
    led_nxt  = led_r;
    me_nxt   = me_r;
    be_nxt   = be_r;
    case (item.op)
      OP_TICK: begin
        if (mov_r) begin
          if (me_r != MOVE_MAX) begin
            me_nxt = me_r + 1'b1;
          end
          if (MOVE_CMP_W'(me_nxt) >= MOVE_CMP_W'(cfg.move_time_ms)) begin
            pos_nxt = tgt_r;
            mov_nxt = 1'b0;
          end
        end
        if (be_r != BLINK_MAX) begin
          be_nxt = be_r + 1'b1;
        end
        if (pump_r || mov_nxt) begin
          if (BLINK_CMP_W'(be_nxt) >= BLINK_CMP_W'(cfg.blink_period_ms)) begin
            be_nxt  = '0;
            led_nxt = ~led_r;
          end
        end else begin
          led_nxt = 1'b0;
        end
      end
      OP_PUMP: begin
        pump_nxt = item.value;
      end
      OP_SHADE: begin
        // A command matching the resting position or the move in progress is dropped.
        if (!((!mov_r && item.value == pos_r) || (mov_r && item.value == tgt_r))) begin
          tgt_nxt = item.value;
          mov_nxt = 1'b1;
          me_nxt  = '0;
        end
      end
      default: begin
        pump_nxt = pump_r;
      end
    endcase
  end

  always_comb begin
    res.pump_pin        = pump_nxt ^ ~cfg.pump_active_high;
    res.open_pin        = (mov_nxt & tgt_nxt) ^ ~cfg.shade_active_high;
    res.close_pin       = (mov_nxt & ~tgt_nxt) ^ ~cfg.shade_active_high;
    res.led_pin         = led_nxt;
    res.pump_running    = pump_nxt;
    res.shade_is_open   = pos_nxt;
    res.shade_in_motion = mov_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pump_r <= 1'b0;
      pos_r  <= 1'b0;
      mov_r  <= 1'b0;
      tgt_r  <= 1'b0;
      led_r  <= 1'b0;
      me_r   <= '0;
      be_r   <= '0;
    end else if (go) begin
      pump_r <= pump_nxt;
      pos_r  <= pos_nxt;
      mov_r  <= mov_nxt;
      tgt_r  <= tgt_nxt;
      led_r  <= led_nxt;
      me_r   <= me_nxt;
      be_r   <= be_nxt;
    end
  end

  // An idle tick forces the LED low.
  a_idle_led_low: assert property (@(posedge clk) disable iff (!rst_n)
    (go && item.op == OP_TICK && !pump_r && !mov_nxt) |=> !led_r)
    else $error("LED not forced low on idle tick");

  // A shade command that starts or reverses a move restarts the move timer.
  a_move_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (go && item.op == OP_SHADE && tgt_nxt != tgt_r) |=> (mov_r && me_r == '0))
    else $error("move timer not restarted on new shade command");

  // The resting position changes only when a move completes on a tick.
  a_pos_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (go && pos_nxt != pos_r) |-> (item.op == OP_TICK && mov_r && !mov_nxt))
    else $error("shade position changed outside a completed move");

endmodule

// ===== design/timed_actuator_controller_core.sv =====
// Top level of the timed actuator controller: input stage, core, result register.
//
// This block runs a pump and a shade motor that drives open or closed for a fixed
// time, and blinks a status LED while either is active. Every input transaction is
// a one-millisecond tick (op 0), a pump command (op 1) or a shade command (op 2),
// and each yields exactly one result transaction with the pin levels and status
// after that transaction. A transaction is registered in the input stage on
// acceptance, processed in one pass of logic once the result register is free or
// emptying, and placed in the result register, which presents the result; one
// transaction is taken every cycle while the result side keeps up. The result
// register is the only buffer on the way out: when the result side stalls, the
// input stage holds its transaction and stalls the input side in the same cycle.
// Configuration writes (index 0 move time, 1 blink period, 2 pump polarity, 3
// shade polarity) are always taken and should be issued only while no
// transaction is in flight; writes to other indexes are dropped.
module timed_actuator_controller_core import tac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  out_t res;

  // Input stage holding one accepted transaction.
  logic stg_v_r, stg_v_nxt;
  in_t  stg_r;

  // Result register.
  logic out_v_r, out_v_nxt;
  out_t out_r;

  // The staged transaction moves on when the result register is free or emptying.
  logic advance;

  assign cfg_ready = 1'b1;

  tac_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tac_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (advance),
    .item  (stg_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign advance  = stg_v_r && (!out_v_r || !out_stall);
  assign in_stall = stg_v_r && !advance;

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (!in_stall) begin
      stg_v_nxt = in_valid;
    end
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stg_r <= in_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Exactly one motor pin is in its driving level while the shade moves, none otherwise.
  a_motor_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_r.open_pin != out_r.close_pin) == out_r.shade_in_motion))
    else $error("motor pin levels inconsistent with motion flag");

  // Every processed transaction lands in the result register.
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("processed transaction produced no result");

  // A held result register always stalls a waiting staged transaction.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_v_r && out_v_r && out_stall) |=> (stg_v_r && out_v_r))
    else $error("staged or result transaction lost under stall");

endmodule
